// ===== design/bpe_pkg.sv =====
// shared types and header constants for the bmp pixel extractor
`default_nettype none

package bpe_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 32;
    localparam int unsigned ROW_CNT_W  = 34;
    localparam int unsigned PAD_W      = 2;

    // header field positions (little-endian, four bytes each)
    localparam logic [POS_W-1:0] OFFSET_POS   = 32'd10;
    localparam logic [POS_W-1:0] WIDTH_POS    = 32'd18;
    localparam logic [POS_W-1:0] HEIGHT_POS   = 32'd22;
    localparam logic [POS_W-1:0] HEADER_BYTES = 32'd26;
    localparam logic [POS_W-1:0] FIELD_BYTES  = 32'd4;
    localparam logic [POS_W-1:0] POS_MAX      = '1;

    typedef struct packed {
        logic [BYTE_W-1:0] file_byte;
        logic              start_of_file;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_byte;
        logic              row_end;
        logic              image_end;
    } result_t;

endpackage

`default_nettype wire

// ===== design/bpe_in_reg.sv =====
// input register holding one file byte until the parser takes it
`default_nettype none

module bpe_in_reg (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            item_valid,
    output logic           item_ready,
    input  bpe_pkg::item_t item,
    input  wire            advance,
    output logic           held_valid,
    output bpe_pkg::item_t held_item
);
    import bpe_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign item_ready = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

endmodule

`default_nettype wire

// ===== design/bpe_parser.sv =====
// header capture, offset skip, row and padding counters for one byte per cycle while the result register has room
`default_nettype none

module bpe_parser (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              advance,
    input  bpe_pkg::item_t   item,
    output logic             result_valid,
    output bpe_pkg::result_t result
);
    import bpe_pkg::*;

    logic [POS_W-1:0]     byte_position_reg, byte_position_next;
    logic [POS_W-1:0]     data_offset_reg, data_offset_next;
    logic [POS_W-1:0]     image_width_reg, image_width_next;
    logic [POS_W-1:0]     image_height_reg, image_height_next;
    logic [ROW_CNT_W-1:0] row_byte_count_reg, row_byte_count_next;
    logic [ROW_CNT_W-1:0] row_last_reg, row_last_next;
    logic [POS_W-1:0]     row_index_reg, row_index_next;
    logic [POS_W-1:0]     height_last_reg, height_last_next;
    logic [PAD_W-1:0]     pad_remaining_reg, pad_remaining_next;
    logic                 image_done_reg, image_done_next;

    logic [POS_W-1:0] pos;
    logic [1:0]       lane;
    logic [4:0]       lane_bit;
    logic             last_in_row;
    logic             last_row;

    assign pos      = byte_position_reg;
    assign lane     = pos[1:0] - OFFSET_POS[1:0];
    assign lane_bit = {lane, 3'b000};

    // counters never pass their last value, so equality marks the end
    assign last_in_row = (row_byte_count_reg == row_last_reg);
    assign last_row    = (row_index_reg == height_last_reg);

    always_comb
    begin
        byte_position_next  = byte_position_reg;
        data_offset_next    = data_offset_reg;
        image_width_next    = image_width_reg;
        image_height_next   = image_height_reg;
        row_byte_count_next = row_byte_count_reg;
        row_index_next      = row_index_reg;
        pad_remaining_next  = pad_remaining_reg;
        image_done_next     = image_done_reg;
        result_valid        = 1'b0;
        result.pixel_byte   = item.file_byte;
        result.row_end      = 1'b0;
        result.image_end    = 1'b0;

        if (item.start_of_file)
        begin
            // restart: this byte is position 0, which captures nothing
            byte_position_next  = 32'd1;
            data_offset_next    = '0;
            image_width_next    = '0;
            image_height_next   = '0;
            row_byte_count_next = '0;
            row_index_next      = '0;
            pad_remaining_next  = '0;
            image_done_next     = 1'b0;
        end
        else
        begin
            if (pos != POS_MAX)
            begin
                byte_position_next = pos + 32'd1;
            end

            if (pos < HEADER_BYTES)
            begin
                if (pos >= OFFSET_POS && pos < OFFSET_POS + FIELD_BYTES)
                begin
                    data_offset_next[lane_bit +: BYTE_W] = item.file_byte;
                end
                else if (pos >= WIDTH_POS && pos < WIDTH_POS + FIELD_BYTES)
                begin
                    image_width_next[lane_bit +: BYTE_W] = item.file_byte;
                end
                else if (pos >= HEIGHT_POS && pos < HEIGHT_POS + FIELD_BYTES)
                begin
                    image_height_next[lane_bit +: BYTE_W] = item.file_byte;
                end
            end
            else if (pos >= data_offset_reg && !image_done_reg
                     && image_width_reg != '0 && image_height_reg != '0)
            begin
                if (pad_remaining_reg != '0)
                begin
                    pad_remaining_next = pad_remaining_reg - 2'd1;
                end
                else
                begin
                    result_valid = 1'b1;
                    if (last_in_row)
                    begin
                        result.row_end      = 1'b1;
                        row_byte_count_next = '0;
                        row_index_next      = row_index_reg + 32'd1;
                        if (last_row)
                        begin
                            result.image_end = 1'b1;
                            image_done_next  = 1'b1;
                        end
                        else
                        begin
                            // row of 3*w bytes needs (-3w) mod 4 = w mod 4 pad bytes
                            pad_remaining_next = image_width_reg[PAD_W-1:0];
                        end
                    end
                    else
                    begin
                        row_byte_count_next = row_byte_count_reg + 34'd1;
                    end
                end
            end
        end

        // derived limits follow the captured fields with no lag
        row_last_next    = {1'b0, image_width_next, 1'b0}
                           + {2'b00, image_width_next} - 34'd1;
        height_last_next = image_height_next - 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg  <= '0;
            data_offset_reg    <= '0;
            image_width_reg    <= '0;
            image_height_reg   <= '0;
            row_byte_count_reg <= '0;
            row_last_reg       <= '1;
            row_index_reg      <= '0;
            height_last_reg    <= '1;
            pad_remaining_reg  <= '0;
            image_done_reg     <= 1'b0;
        end
        else if (advance)
        begin
            byte_position_reg  <= byte_position_next;
            data_offset_reg    <= data_offset_next;
            image_width_reg    <= image_width_next;
            image_height_reg   <= image_height_next;
            row_byte_count_reg <= row_byte_count_next;
            row_last_reg       <= row_last_next;
            row_index_reg      <= row_index_next;
            height_last_reg    <= height_last_next;
            pad_remaining_reg  <= pad_remaining_next;
            image_done_reg     <= image_done_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bpe_out_reg.sv =====
// result register on the pixel side
`default_nettype none

module bpe_out_reg (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              load,
    input  bpe_pkg::result_t result,
    output logic             can_load,
    output logic             pixel_valid,
    input  wire              pixel_ready,
    output bpe_pkg::result_t held_result
);
    import bpe_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign can_load    = !valid_reg || pixel_ready;
    assign pixel_valid = valid_reg;
    assign held_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (pixel_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== design/bmp24_pixel_extractor.sv =====
// bmp 24-bit pixel extractor: one file byte in, at most one pixel byte out
// a byte is held in the input register, stepped through the parser and registered in the result register
// throughput: one byte per cycle, limited by the single state update per byte
// a waiting result stalls the parser; one more byte then waits in the input register
// rst_n clears all parse state; the first byte after reset is file position 0
`default_nettype none

module bmp24_pixel_extractor (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        item_valid,
    output logic       item_ready,
    input  wire  [7:0] file_byte,
    input  wire        start_of_file,
    output logic       pixel_valid,
    input  wire        pixel_ready,
    output logic [7:0] pixel_byte,
    output logic       row_end,
    output logic       image_end
);
    import bpe_pkg::*;

    item_t   in_item;
    item_t   held_item;
    result_t step_result;
    result_t out_result;
    logic    held_valid;
    logic    step_valid;
    logic    can_load;
    logic    advance;
    logic    load;

    assign in_item.file_byte     = file_byte;
    assign in_item.start_of_file = start_of_file;

    // a byte steps through the parser when the result register has room
    assign advance = held_valid && can_load;
    assign load    = advance && step_valid;

    bpe_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    bpe_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item         (held_item),
        .result_valid (step_valid),
        .result       (step_result)
    );

    bpe_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .result      (step_result),
        .can_load    (can_load),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .held_result (out_result)
    );

    assign pixel_byte = out_result.pixel_byte;
    assign row_end    = out_result.row_end;
    assign image_end  = out_result.image_end;

    // the end of the image always closes a row
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && image_end |-> row_end)
        else $error("image_end without row_end");

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |-> !load)
        else $error("result register overwritten");

    // a held byte is never dropped without passing the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        held_valid && !advance |=> held_valid)
        else $error("input byte lost");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// testbench for bmp24_pixel_extractor: directed byte script, random bmp files, scoreboard
`default_nettype none

module testbench;

    import bpe_pkg::*;

    localparam int unsigned CLK_HALF     = 10;
    localparam int unsigned SCRIPT_LEN   = 23;
    localparam int unsigned RANDOM_BYTES = 1250;
    localparam int unsigned IDLE_PCT     = 22;

    typedef enum logic [1:0] {
        ROW_QUIET,   // no pixel may come out of this byte
        ROW_PIXEL,   // pixel typed into the script
        ROW_PREDICT  // whatever the parser model says
    } script_kind_t;

    typedef struct {
        logic [7:0]   value;
        logic         sof;
        int unsigned  count;
        script_kind_t kind;
        result_t      want;
    } script_row_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       item_valid    = 1'b0;
    logic [7:0] file_byte     = 8'h00;
    logic       start_of_file = 1'b0;
    logic       pixel_ready   = 1'b0;
    logic       item_ready;
    logic       pixel_valid;
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       image_end;

    // parser model state
    logic [POS_W-1:0]     next_pos     = '0;
    logic [31:0]          offset_q     = '0;
    logic [31:0]          width_q      = '0;
    logic [31:0]          height_q     = '0;
    logic [ROW_CNT_W-1:0] row_count_q  = '0;
    logic [PAD_W-1:0]     pad_left_q   = '0;
    logic [31:0]          rows_done_q  = '0;
    logic                 img_done_q   = 1'b0;

    result_t     pending_pixels [$];
    script_row_t byte_script [SCRIPT_LEN];

    int unsigned bytes_accepted = 0;
    int unsigned files_sent     = 0;
    int unsigned pixels_checked = 0;
    int unsigned rows_seen      = 0;
    int unsigned images_seen    = 0;
    int unsigned mismatch_count = 0;
    int unsigned hold_left      = 0;
    bit          held_off       = 1'b0;
    bit          calm_stretch   = 1'b0;

    bmp24_pixel_extractor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .file_byte     (file_byte),
        .start_of_file (start_of_file),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel_byte    (pixel_byte),
        .row_end       (row_end),
        .image_end     (image_end)
    );

    always #(CLK_HALF) clk = ~clk;

    // advance the parser by one file byte, giving the pixel it yields if any
    task automatic parse_file_byte(input logic [7:0] value, input logic sof,
                                   output bit produced, output result_t pixel);
        logic [POS_W-1:0]     pos;
        logic [ROW_CNT_W-1:0] row_len;
        produced = 1'b0;
        pixel    = '0;
        if (sof)
        begin
            next_pos    = '0;
            offset_q    = '0;
            width_q     = '0;
            height_q    = '0;
            row_count_q = '0;
            pad_left_q  = '0;
            rows_done_q = '0;
            img_done_q  = 1'b0;
        end
        pos = next_pos;
        if (next_pos != POS_MAX)
            next_pos = next_pos + 1;
        if (pos < HEADER_BYTES)
        begin
            if (pos >= OFFSET_POS && pos < OFFSET_POS + FIELD_BYTES)
                offset_q[(pos - OFFSET_POS) * 8 +: 8] = value;
            else if (pos >= WIDTH_POS && pos < WIDTH_POS + FIELD_BYTES)
                width_q[(pos - WIDTH_POS) * 8 +: 8] = value;
            else if (pos >= HEIGHT_POS && pos < HEIGHT_POS + FIELD_BYTES)
                height_q[(pos - HEIGHT_POS) * 8 +: 8] = value;
            return;
        end
        if (pos < offset_q || img_done_q || width_q == 0 || height_q == 0)
            return;
        if (pad_left_q != 0)
        begin
            pad_left_q = pad_left_q - 2'd1;
            return;
        end
        row_len          = {2'b00, width_q} * 34'd3;
        produced         = 1'b1;
        pixel.pixel_byte = value;
        row_count_q      = row_count_q + 1;
        if (row_count_q >= row_len)
        begin
            pixel.row_end = 1'b1;
            row_count_q   = '0;
            rows_done_q   = rows_done_q + 1;
            if (rows_done_q >= height_q)
            begin
                pixel.image_end = 1'b1;
                img_done_q      = 1'b1;
            end
            else
                pad_left_q = 2'b00 - row_len[1:0];
        end
    endtask

    task automatic offer_byte(input logic [7:0] value, input logic sof,
                              input script_kind_t kind, input result_t want);
        bit      produced;
        result_t predicted;
        while (!calm_stretch && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        file_byte     <= value;
        start_of_file <= sof;
        do
            @(posedge clk);
        while (!item_ready);
        parse_file_byte(value, sof, produced, predicted);
        bytes_accepted++;
        case (kind)
            ROW_PREDICT: if (produced) pending_pixels.push_back(predicted);
            ROW_PIXEL:   pending_pixels.push_back(want);
            default:     ;
        endcase
    endtask

    task automatic send_random_file();
        logic [7:0]  hdr [26];
        logic [31:0] offset;
        logic [31:0] width;
        logic [31:0] height;
        int unsigned mode;
        int unsigned total;
        int unsigned row_len;
        int unsigned pick;
        mode = $urandom_range(99);
        files_sent++;
        if (mode >= 90)
        begin
            // loose noise, an occasional stray start mark among it
            total = $urandom_range(1, 30);
            for (int unsigned i = 0; i < total; i++)
                offer_byte(8'($urandom_range(255)), $urandom_range(15) == 0,
                           ROW_PREDICT, '0);
            return;
        end
        pick = $urandom_range(99);
        if (pick < 35)
            offset = $urandom_range(25);
        else if (pick < 90)
            offset = $urandom_range(26, 45);
        else
            offset = $urandom_range(46, 80);
        pick = $urandom_range(99);
        if (pick < 5)
            width = 0;
        else if (pick < 15)
            width = $urandom_range(7, 40);
        else
            width = $urandom_range(1, 6);
        height = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 4);
        if (mode >= 80)
        begin
            // header with wild values, file cut short
            offset = $urandom();
            width  = $urandom();
            height = $urandom();
        end
        for (int unsigned i = 0; i < HEADER_BYTES; i++)
            hdr[i] = 8'($urandom_range(255));
        if (mode < 80)
        begin
            hdr[0] = 8'h42;
            hdr[1] = 8'h4d;
        end
        for (int unsigned i = 0; i < FIELD_BYTES; i++)
        begin
            hdr[OFFSET_POS + i] = offset[i * 8 +: 8];
            hdr[WIDTH_POS + i]  = width[i * 8 +: 8];
            hdr[HEIGHT_POS + i] = height[i * 8 +: 8];
        end
        total = (offset < HEADER_BYTES) ? HEADER_BYTES : offset;
        if (mode >= 80)
            total = HEADER_BYTES + $urandom_range(40);
        else if (width == 0 || height == 0)
            total += $urandom_range(8);
        else
        begin
            row_len = 3 * width;
            total  += height * (row_len + ((4 - row_len % 4) % 4)) + $urandom_range(3);
        end
        // some well-formed files stop part way and the next start mark restarts
        if (mode >= 70 && mode < 80)
            total = $urandom_range(1, total);
        for (int unsigned i = 0; i < total; i++)
            offer_byte((i < HEADER_BYTES) ? hdr[i] : 8'($urandom_range(255)), i == 0,
                       ROW_PREDICT, '0);
    endtask

    // receiver: scoreboard and ready pattern, including one long hold-off
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pixel_valid && pixel_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("unexpected pixel transaction: %02h row_end %0b image_end %0b",
                           pixel_byte, row_end, image_end);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    rows_seen   += row_end;
                    images_seen += image_end;
                    if (pixel_byte !== want.pixel_byte)
                    begin
                        $error("pixel_byte: expected %02h, got %02h",
                               want.pixel_byte, pixel_byte);
                        mismatch_count++;
                    end
                    if (row_end !== want.row_end)
                    begin
                        $error("row_end: expected %0b, got %0b", want.row_end, row_end);
                        mismatch_count++;
                    end
                    if (image_end !== want.image_end)
                    begin
                        $error("image_end: expected %0b, got %0b", want.image_end, image_end);
                        mismatch_count++;
                    end
                end
            end
            if (!held_off && bytes_accepted >= 900)
            begin
                held_off  = 1'b1;
                hold_left = 400;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pixel_ready <= 1'b0;
            end
            else
                pixel_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        #(2 * CLK_HALF * 200000);
        $display("** bmp24_pixel_extractor: FAILED **");
        $finish;
    end

    initial
    begin
        int unsigned directed_bytes;
        // first file has no start mark; offset 0 falls back to byte 26
        // 1x2 image, one pad byte between the rows, then trailing bytes
        byte_script = '{
            '{8'h42, 1'b0, 1,  ROW_QUIET,   '0},
            '{8'h4d, 1'b0, 1,  ROW_QUIET,   '0},
            '{8'h00, 1'b0, 16, ROW_QUIET,   '0},
            '{8'h01, 1'b0, 1,  ROW_QUIET,   '0},
            '{8'h00, 1'b0, 3,  ROW_QUIET,   '0},
            '{8'h02, 1'b0, 1,  ROW_QUIET,   '0},
            '{8'h00, 1'b0, 3,  ROW_QUIET,   '0},
            '{8'h00, 1'b0, 1,  ROW_PIXEL,   '{8'h00, 1'b0, 1'b0}},
            '{8'hff, 1'b0, 1,  ROW_PIXEL,   '{8'hff, 1'b0, 1'b0}},
            '{8'h5a, 1'b0, 1,  ROW_PIXEL,   '{8'h5a, 1'b1, 1'b0}},
            '{8'ha5, 1'b0, 1,  ROW_QUIET,   '0},
            '{8'h01, 1'b0, 1,  ROW_PIXEL,   '{8'h01, 1'b0, 1'b0}},
            '{8'h80, 1'b0, 1,  ROW_PIXEL,   '{8'h80, 1'b0, 1'b0}},
            '{8'h7f, 1'b0, 1,  ROW_PIXEL,   '{8'h7f, 1'b1, 1'b1}},
            '{8'hff, 1'b0, 2,  ROW_QUIET,   '0},
            // restart with zero width: nothing comes out at all
            '{8'h42, 1'b1, 1,  ROW_QUIET,   '0},
            '{8'h4d, 1'b0, 9,  ROW_QUIET,   '0},
            '{8'h1b, 1'b0, 1,  ROW_QUIET,   '0},
            '{8'h00, 1'b0, 11, ROW_QUIET,   '0},
            '{8'h03, 1'b0, 1,  ROW_QUIET,   '0},
            '{8'h00, 1'b0, 3,  ROW_QUIET,   '0},
            '{8'hc3, 1'b0, 4,  ROW_PREDICT, '0},
            '{8'h3c, 1'b0, 2,  ROW_PREDICT, '0}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (byte_script[r])
            for (int unsigned k = 0; k < byte_script[r].count; k++)
                offer_byte(byte_script[r].value, byte_script[r].sof && k == 0,
                           byte_script[r].kind, byte_script[r].want);
        files_sent     = 2;
        directed_bytes = bytes_accepted;

        while (bytes_accepted - directed_bytes < RANDOM_BYTES)
        begin
            calm_stretch = (bytes_accepted >= 400 && bytes_accepted < 700);
            send_random_file();
        end
        calm_stretch = 1'b0;
        item_valid <= 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d file bytes in %0d files, %0d pixel transactions checked",
                 bytes_accepted, files_sent, pixels_checked);
        $display("with %0d row ends and %0d image ends seen", rows_seen, images_seen);
        if (mismatch_count == 0)
            $display("** bmp24_pixel_extractor: PASSED **");
        else
            $display("** bmp24_pixel_extractor: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
